@@ hdl/hjdf_pkg.sv @@
`default_nettype none
package hjdf_pkg;

  localparam int unsigned BAND_W   = 12;
  localparam int unsigned OUT_W    = 12;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_HYST_BAND = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_BAND = 8'd1;

  localparam logic [BAND_W-1:0] HYST_BAND_RST = 12'd16;
  localparam logic [BAND_W-1:0] JUMP_BAND_RST = 12'd256;

  typedef struct packed {
    logic [BAND_W-1:0] hyst_band;
    logic [BAND_W-1:0] jump_band;
  } cfg_t;

endpackage
`default_nettype wire

@@ hdl/hysteresis_jump_damping_filter.sv @@
`default_nettype none
// Hysteresis / jump-damping filter for raw converter samples.
// Input channel: in_valid_i / in_ready_o with raw_sample_i, one sample per item.
// Output channel: out_valid_o / out_ready_i with filtered_sample_o, one value
// per input item, in order: the held value after that sample.
// Config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects
// 0 = hysteresis band, 1 = jump band; other indexes are ignored. cfg_ready_o
// is always high; write only while no item is in flight.
// An accepted item moves on from the input register when the output is free.
// Throughput: one item per clock without an output stall, set by the single
// compare/average stage between the input register and the result register.
// Stall: a held result keeps out_valid_o and its value; one more item waits in
// the input register, after which in_ready_o drops until the result is taken.
// Reset: both bands return to 16 and 256, the held value clears and the next
// sample is adopted as it is; the pipeline empties.
module hysteresis_jump_damping_filter #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]        raw_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [hjdf_pkg::OUT_W-1:0]         filtered_sample_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [hjdf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [hjdf_pkg::BAND_W-1:0]   cfg_data_i
);

  hjdf_pkg::cfg_t cfg;

  logic                   in_vld_q, in_vld_d;
  logic [SAMPLE_BITS-1:0] in_smp_q;
  logic                   out_vld_q, out_vld_d;
  logic [SAMPLE_BITS-1:0] held_q, held_d;
  logic                   first_q;
  logic                   advance, accept;

  hjdf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hjdf_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
    .sample_i (in_smp_q),
    .held_i   (held_q),
    .first_i  (first_q),
    .cfg_i    (cfg),
    .held_o   (held_d)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d  = accept ? 1'b1 : (advance ? 1'b0 : in_vld_q);
    out_vld_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      first_q   <= 1'b1;
      held_q    <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        first_q <= 1'b0;
        held_q  <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_smp_q <= raw_sample_i;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign filtered_sample_o = hjdf_pkg::OUT_W'(held_q);

endmodule
`default_nettype wire

@@ hdl/hjdf_cfg.sv @@
`default_nettype none
module hjdf_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [hjdf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [hjdf_pkg::BAND_W-1:0]   cfg_data_i,
  output hjdf_pkg::cfg_t                     cfg_o
);

  hjdf_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hjdf_pkg::REG_HYST_BAND: cfg_d.hyst_band = cfg_data_i;
        hjdf_pkg::REG_JUMP_BAND: cfg_d.jump_band = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hyst_band <= hjdf_pkg::HYST_BAND_RST;
      cfg_q.jump_band <= hjdf_pkg::JUMP_BAND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ hdl/hjdf_core.sv @@
`default_nettype none
module hjdf_core #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [SAMPLE_BITS-1:0] held_i,
  input  wire logic                   first_i,
  input  wire hjdf_pkg::cfg_t         cfg_i,
  output logic [SAMPLE_BITS-1:0]      held_o
);

  localparam int unsigned DW =
    ((SAMPLE_BITS > hjdf_pkg::BAND_W) ? SAMPLE_BITS : hjdf_pkg::BAND_W) + 2;

  logic signed [DW-1:0] s_x, p_x, h_x, j_x, d;
  logic [SAMPLE_BITS:0]  sum;
  logic follow_up, follow_dn, jump;

  always_comb begin
    s_x = $signed(DW'(sample_i));
    p_x = $signed(DW'(held_i));
    h_x = $signed(DW'(cfg_i.hyst_band));
    j_x = $signed(DW'(cfg_i.jump_band));
    d   = s_x - p_x;
    sum = {1'b0, held_i} + {1'b0, sample_i};

    follow_up = (d > h_x) && (d < j_x);
    follow_dn = (d < -h_x) && (d > -j_x);
    jump      = (d >= j_x) || (d <= -j_x);

    if (first_i) begin
      held_o = sample_i;
    end else if (follow_up || follow_dn) begin
      held_o = sample_i;
    end else if (jump) begin
      held_o = sum[SAMPLE_BITS:1];
    end else begin
      held_o = held_i;
    end
  end

endmodule
`default_nettype wire

@@ hdl/hjdf_checker.sv @@
`default_nettype none
module hjdf_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_ready_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [hjdf_pkg::OUT_W-1:0] filtered_sample_o,
  input wire logic                  cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_sample_o))
    else $error("stalled result item changed");

  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result item right after reset");

  a_cfg_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind hysteresis_jump_damping_filter hjdf_checker u_hjdf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .filtered_sample_o (filtered_sample_o),
  .cfg_ready_o       (cfg_ready_o)
);
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int unsigned SW = 12;
  localparam int MAX_SAMPLE = (1 << SW) - 1;
  localparam int MAX_BAND = (1 << hjdf_pkg::BAND_W) - 1;
  localparam int RANDOM_ITEMS = 1750;
  localparam int PHASES = 14;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [hjdf_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
  localparam logic [hjdf_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

  logic                           clk;
  logic                           rst_ni;
  logic                           in_valid;
  logic                           in_ready;
  logic [SW-1:0]                  raw_sample;
  logic                           out_valid;
  logic                           out_ready;
  logic [hjdf_pkg::OUT_W-1:0]     filtered_sample;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [hjdf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hjdf_pkg::BAND_W-1:0]    cfg_data;

  // model of the filter
  logic [hjdf_pkg::OUT_W-1:0]  mdl_held;
  logic                        mdl_first;
  logic [hjdf_pkg::BAND_W-1:0] mdl_hyst;
  logic [hjdf_pkg::BAND_W-1:0] mdl_jump;

  logic [hjdf_pkg::OUT_W-1:0] filtered_expected[$];
  int errors;
  int cycles;

  hysteresis_jump_damping_filter #(
    .SAMPLE_BITS(SW)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .raw_sample_i     (raw_sample),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .filtered_sample_o(filtered_sample),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("tb: done, errors");
    $finish;
  end

  function automatic logic [hjdf_pkg::OUT_W-1:0] next_filtered(input logic [SW-1:0] s);
    int r;
    int p;
    int h;
    int j;
    if (mdl_first) begin
      mdl_first = 1'b0;
      mdl_held  = s;
    end
    r = int'(s);
    p = int'(mdl_held);
    h = int'(mdl_hyst);
    j = int'(mdl_jump);
    if (r > p + h && r < p + j) begin
      mdl_held = s;
    end else if (r < p - h && r > p - j) begin
      mdl_held = s;
    end else if (r >= p + j || r <= p - j) begin
      mdl_held = hjdf_pkg::OUT_W'((p + r) / 2);
    end
    return mdl_held;
  endfunction

  function automatic logic [SW-1:0] clamp_sample(input int t);
    if (t < 0) return '0;
    if (t > MAX_SAMPLE) return SW'(MAX_SAMPLE);
    return SW'(t);
  endfunction

  // mostly samples placed on the band edges around the held value
  function automatic logic [SW-1:0] pick_sample();
    int span;
    int t;
    t = int'(mdl_held);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        case ($urandom_range(0, 5))
          0: span = int'(mdl_hyst);
          1: span = int'(mdl_hyst) + 1;
          2: span = int'(mdl_jump) - 1;
          3: span = int'(mdl_jump);
          4: span = int'(mdl_jump) + 1;
          default: span = $urandom_range(0, int'(mdl_jump) + int'(mdl_hyst) + 8);
        endcase
        t = $urandom_range(0, 1) ? t + span : t - span;
      end
      6, 7: t = $urandom_range(0, MAX_SAMPLE);
      8: t = $urandom_range(0, 1) ? MAX_SAMPLE : 0;
      default: t = int'(mdl_held);
    endcase
    return clamp_sample(t);
  endfunction

  task automatic send_sample(input logic [SW-1:0] s);
    @(negedge clk);
    in_valid   <= 1'b1;
    raw_sample <= s;
    do @(posedge clk); while (!in_ready);
    filtered_expected.push_back(next_filtered(s));
  endtask

  task automatic send_offset(input int d);
    send_sample(clamp_sample(int'(mdl_held) + d));
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (filtered_expected.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [hjdf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hjdf_pkg::BAND_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == hjdf_pkg::REG_HYST_BAND) begin
      mdl_hyst = data;
    end else if (idx == hjdf_pkg::REG_JUMP_BAND) begin
      mdl_jump = data;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_bands(input int hyst, input int jump);
    drain();
    cfg_write(hjdf_pkg::REG_HYST_BAND, hjdf_pkg::BAND_W'(hyst));
    cfg_write(hjdf_pkg::REG_JUMP_BAND, hjdf_pkg::BAND_W'(jump));
  endtask

  // first sample adopted, then the reset bands on both sides
  task automatic test_reset_bands();
    send_sample(SW'(MAX_SAMPLE));
    send_offset(-16);
    send_offset(-17);
    send_offset(16);
    send_offset(-256);
    send_offset(-255);
    send_sample('0);
    send_offset(17);
    send_offset(256);
    send_offset(255);
  endtask

  task automatic test_wide_bands();
    set_bands(0, MAX_BAND);
    send_offset(1);
    send_offset(-1);
    send_offset(0);
    send_sample('0);
    send_sample(SW'(MAX_SAMPLE));
  endtask

  // jump band at or below hysteresis band: only averaging can act
  task automatic test_inverted_bands();
    set_bands(MAX_BAND, 0);
    send_sample(SW'(MAX_SAMPLE));
    send_sample('0);
    send_sample(SW'(1));
    send_offset(0);
    set_bands(100, 100);
    send_offset(50);
    send_offset(100);
    send_offset(-99);
    send_offset(-100);
  endtask

  task automatic test_unused_index();
    drain();
    cfg_write(REG_UNUSED_LO, '0);
    cfg_write(REG_UNUSED_HI, hjdf_pkg::BAND_W'(MAX_BAND));
    send_offset(99);
    send_offset(100);
  endtask

  task automatic test_random();
    int per_phase;
    int sent;
    int burst;
    per_phase = RANDOM_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_bands(int'(hjdf_pkg::HYST_BAND_RST), int'(hjdf_pkg::JUMP_BAND_RST));
        1: set_bands(0, 0);
        2: set_bands(MAX_BAND, MAX_BAND);
        3: set_bands(0, MAX_BAND);
        4, 5, 6, 7, 8: set_bands($urandom_range(0, 64), $urandom_range(0, 512));
        9: set_bands($urandom_range(100, 600), $urandom_range(0, 100));
        default: set_bands($urandom_range(0, MAX_BAND), $urandom_range(0, MAX_BAND));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(hjdf_pkg::CFG_IDX_W'($urandom_range(2, 255)),
                  hjdf_pkg::BAND_W'($urandom_range(0, MAX_BAND)));
      end
      sent = 0;
      while (sent < per_phase) begin
        burst = $urandom_range(1, 24);
        for (int i = 0; i < burst && sent < per_phase; i++) begin
          send_sample(pick_sample());
          sent++;
        end
        case ($urandom_range(0, 7))
          0: drain();
          1, 2, 3: ;
          default: idle_input($urandom_range(1, 6));
        endcase
      end
    end
  endtask

  always @(posedge clk) begin : check_output
    logic [hjdf_pkg::OUT_W-1:0] want;
    if (rst_ni && out_valid && out_ready) begin
      if (filtered_expected.size() == 0) begin
        $display("%0t: unexpected item, filtered_sample %0d", $time, filtered_sample);
        errors++;
      end else begin
        want = filtered_expected.pop_front();
        if (filtered_sample !== want) begin
          $display("%0t: filtered_sample expected %0d, got %0d", $time, want, filtered_sample);
          errors++;
        end
      end
    end
  end

  initial begin : sink_pattern
    int len;
    int mode;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(1, 40);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  initial begin
    errors     = 0;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    raw_sample = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    mdl_held   = '0;
    mdl_first  = 1'b1;
    mdl_hyst   = hjdf_pkg::HYST_BAND_RST;
    mdl_jump   = hjdf_pkg::JUMP_BAND_RST;
    repeat (8) @(negedge clk);
    rst_ni <= 1'b1;

    test_reset_bands();
    test_wide_bands();
    test_inverted_bands();
    test_unused_index();
    test_random();

    drain();
    repeat (20) @(posedge clk);
    if (filtered_expected.size() != 0) begin
      $display("%0t: %0d items never came out", $time, filtered_expected.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
